### rtl/core/mi4_pkg.sv
package mi4_pkg;

	// Default number of fraction bits of the fixed-point format.
	localparam int FRAC_BITS_DEF = 16;

	// Wide intermediate value, held in the symmetric signed 64-bit range.
	typedef logic signed [63:0] wide_t;

	// Magnitude of a wide value.
	function automatic logic [63:0] mag64(input wide_t v);
		mag64 = v[63] ? (64'd0 - 64'(v)) : 64'(v);
	endfunction

endpackage

### rtl/core/matrix4_inverse_adjugate.sv
// 4x4 matrix inverse by the adjugate method, signed fixed point with
// FRAC_BITS fraction bits (Q16.16 by default). Rows arrive one item at a time,
// row 0 first; the fourth row starts the computation and the block is not
// ready until all four result rows have been taken. The sixteen 3x3 cofactors
// and the determinant take 148 products on one shared multiplier, each product
// passing through operand fetch, four accumulated 32x32 partial products,
// then truncation and saturation. Each of the sixteen result elements is then
// formed in the bit-serial divider when the matrix is invertible.
// A determinant of zero or of magnitude below the epsilon written by cfg_wdata
// (1 after reset) gives identity rows with invertible low. Results saturate to
// the 32-bit range, and last_row marks the fourth result row.
module matrix4_inverse_adjugate #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] col0_value,
	input  logic signed [31:0] col1_value,
	input  logic signed [31:0] col2_value,
	input  logic signed [31:0] col3_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res0_value,
	output logic signed [31:0] res1_value,
	output logic signed [31:0] res2_value,
	output logic signed [31:0] res3_value,
	output logic               invertible,
	output logic               last_row,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata
);

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_FETCH  = 3'd1;
	localparam logic [2:0] ST_MSTART = 3'd2;
	localparam logic [2:0] ST_MWAIT  = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_ELEM   = 3'd5;
	localparam logic [2:0] ST_DWAIT  = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	localparam logic signed [64:0] WMAX65 = {2'b00, {63{1'b1}}};

	// Index of the n-th of four rows or columns once x is taken out.
	function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] n);
		skip_idx = (n < x) ? n : n + 2'd1;
	endfunction

	function automatic logic [31:0] col_sel(input logic [127:0] row, input logic [1:0] c);
		unique case (c)
			2'd0: col_sel = row[31:0];
			2'd1: col_sel = row[63:32];
			2'd2: col_sel = row[95:64];
			default: col_sel = row[127:96];
		endcase
	endfunction

	logic [2:0]   state_q;
	logic [1:0]   rows_q;
	logic [127:0] mat_mem [4];
	logic [127:0] rowa_q;
	logic [127:0] rowb_q;
	mi4_pkg::wide_t cof_q [16];
	logic [3:0]   cidx_q;
	logic [3:0]   k_q;
	logic         det_ph_q;
	mi4_pkg::wide_t hold_q;
	mi4_pkg::wide_t t0_q;
	mi4_pkg::wide_t t1_q;
	mi4_pkg::wide_t t2_q;
	mi4_pkg::wide_t acc_q;
	mi4_pkg::wide_t det_q;
	logic         ok_q;
	logic [1:0]   orow_q;
	logic [1:0]   ocol_q;
	logic [31:0]  res_q [4];
	logic [30:0]  eps_q;

	logic [1:0]  ci;
	logic [1:0]  cj;
	logic [1:0]  ra;
	logic [1:0]  rb;
	logic [1:0]  na;
	logic [1:0]  nb;
	logic [1:0]  ca;
	logic [1:0]  cb;
	mi4_pkg::wide_t mul_a;
	mi4_pkg::wide_t mul_b;
	logic        mul_start;
	logic        mul_done;
	mi4_pkg::wide_t mul_p;
	mi4_pkg::wide_t add_x;
	logic        add_sub;
	logic signed [64:0] add_s;
	mi4_pkg::wide_t sum;
	logic        div_start;
	logic        div_done;
	logic signed [31:0] div_q;
	logic        ok_now;

	// Operand addressing for the current product.
	always_comb begin
		ci = cidx_q[3:2];
		cj = cidx_q[1:0];
		unique case (k_q)
			4'd0: begin na = 2'd1; nb = 2'd2; end
			4'd1: begin na = 2'd2; nb = 2'd1; end
			4'd2: begin na = 2'd0; nb = 2'd2; end
			4'd3: begin na = 2'd2; nb = 2'd0; end
			4'd4: begin na = 2'd0; nb = 2'd1; end
			4'd5: begin na = 2'd1; nb = 2'd0; end
			4'd6: begin na = 2'd0; nb = 2'd0; end
			4'd7: begin na = 2'd1; nb = 2'd0; end
			default: begin na = 2'd2; nb = 2'd0; end
		endcase
		if (det_ph_q) begin
			ra = 2'd0;
			rb = 2'd0;
			ca = k_q[1:0];
			cb = 2'd0;
		end else begin
			ra = (k_q >= 4'd6) ? skip_idx(ci, 2'd0) : skip_idx(ci, 2'd1);
			rb = skip_idx(ci, 2'd2);
			ca = skip_idx(cj, na);
			cb = skip_idx(cj, nb);
		end
	end

	always_comb begin
		mul_a = 64'($signed(col_sel(rowa_q, ca)));
		if (det_ph_q) begin
			mul_b = cof_q[{2'd0, k_q[1:0]}];
		end else begin
			unique case (k_q)
				4'd6: mul_b = t0_q;
				4'd7: mul_b = t1_q;
				4'd8: mul_b = t2_q;
				default: mul_b = 64'($signed(col_sel(rowb_q, cb)));
			endcase
		end
		mul_start = state_q == ST_MSTART;
	end

	mi4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Shared saturating adder for the cofactor terms and the determinant.
	always_comb begin
		add_x = (det_ph_q || k_q == 4'd7 || k_q == 4'd8) ? acc_q : hold_q;
		add_sub = !det_ph_q && (k_q == 4'd1 || k_q == 4'd3 || k_q == 4'd5 || k_q == 4'd7);
		add_s = add_sub ? (65'(add_x) - 65'(mul_p)) : (65'(add_x) + 65'(mul_p));
		if (add_s > WMAX65) begin
			sum = WMAX65[63:0];
		end else if (add_s < -WMAX65) begin
			sum = -WMAX65[63:0];
		end else begin
			sum = add_s[63:0];
		end
	end

	assign div_start = (state_q == ST_ELEM) && ok_q;
	assign ok_now = (det_q != 64'sd0) && (mi4_pkg::mag64(det_q) >= {33'd0, eps_q});

	mi4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cof_q[{ocol_q, orow_q}]),
		.den    (det_q),
		.done   (div_done),
		.q      (div_q)
	);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			rows_q   <= 2'd0;
			cidx_q   <= 4'd0;
			k_q      <= 4'd0;
			det_ph_q <= 1'b0;
			orow_q   <= 2'd0;
			ocol_q   <= 2'd0;
			ok_q     <= 1'b0;
			eps_q    <= 31'd1;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						rows_q <= rows_q + 2'd1;
						if (rows_q == 2'd3) begin
							cidx_q   <= 4'd0;
							k_q      <= 4'd0;
							det_ph_q <= 1'b0;
							state_q  <= ST_FETCH;
						end
					end
				end
				ST_FETCH: state_q <= ST_MSTART;
				ST_MSTART: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (mul_done) begin
						state_q <= ST_FETCH;
						if (det_ph_q) begin
							if (k_q == 4'd3) begin
								state_q <= ST_DECIDE;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end else if (k_q == 4'd8) begin
							k_q <= 4'd0;
							cidx_q <= cidx_q + 4'd1;
							if (cidx_q == 4'd15) begin
								det_ph_q <= 1'b1;
							end
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				ST_DECIDE: begin
					ok_q    <= ok_now;
					orow_q  <= 2'd0;
					ocol_q  <= 2'd0;
					state_q <= ST_ELEM;
				end
				ST_ELEM: begin
					if (ok_q) begin
						state_q <= ST_DWAIT;
					end else if (ocol_q == 2'd3) begin
						state_q <= ST_OUT;
					end else begin
						ocol_q <= ocol_q + 2'd1;
					end
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (ocol_q == 2'd3) begin
							state_q <= ST_OUT;
						end else begin
							ocol_q  <= ocol_q + 2'd1;
							state_q <= ST_ELEM;
						end
					end
				end
				default: begin
					if (out_ready) begin
						ocol_q <= 2'd0;
						if (orow_q == 2'd3) begin
							state_q <= ST_LOAD;
						end else begin
							orow_q  <= orow_q + 2'd1;
							state_q <= ST_ELEM;
						end
					end
				end
			endcase
		end
	end

	// Datapath registers and the row-wide matrix memory.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid) begin
			mat_mem[rows_q] <= {col3_value, col2_value, col1_value, col0_value};
		end
		if (state_q == ST_FETCH) begin
			rowa_q <= mat_mem[ra];
			rowb_q <= mat_mem[rb];
		end
		if (state_q == ST_MWAIT && mul_done) begin
			if (det_ph_q) begin
				acc_q <= (k_q == 4'd0) ? mul_p : sum;
				if (k_q == 4'd3) begin
					det_q <= sum;
				end
			end else begin
				unique case (k_q)
					4'd0, 4'd2, 4'd4: hold_q <= mul_p;
					4'd1: t0_q <= sum;
					4'd3: t1_q <= sum;
					4'd5: t2_q <= sum;
					4'd6: acc_q <= mul_p;
					4'd7: acc_q <= sum;
					default: cof_q[cidx_q] <= (cidx_q[2] ^ cidx_q[0]) ? -sum : sum;
				endcase
			end
		end
		if (state_q == ST_ELEM && !ok_q) begin
			res_q[ocol_q] <= (orow_q == ocol_q) ? (32'd1 << FRAC_BITS) : 32'd0;
		end
		if (state_q == ST_DWAIT && div_done) begin
			res_q[ocol_q] <= div_q;
		end
	end

	assign in_ready   = state_q == ST_LOAD;
	assign out_valid  = state_q == ST_OUT;
	assign res0_value = $signed(res_q[0]);
	assign res1_value = $signed(res_q[1]);
	assign res2_value = $signed(res_q[2]);
	assign res3_value = $signed(res_q[3]);
	assign invertible = ok_q;
	assign last_row   = orow_q == 2'd3;

endmodule

### rtl/core/mi4_mul.sv
module mi4_mul #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mi4_pkg::wide_t  a,
	input  mi4_pkg::wide_t  b,
	output logic            done,
	output mi4_pkg::wide_t  p
);

	// Four 32x32 partial products are summed in turn, then the
	// fraction bits are dropped and the magnitude is saturated.
	logic        busy_q;
	logic [2:0]  step_q;
	logic [63:0] ua_q;
	logic [63:0] ub_q;
	logic        neg_q;
	logic [127:0] acc_q;
	logic        done_q;
	mi4_pkg::wide_t p_q;

	logic [31:0]  op_a;
	logic [31:0]  op_b;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [63:0]  slo;
	logic         shi_nz;
	logic [63:0]  mres;

	always_comb begin
		op_a = step_q[1] ? ua_q[63:32] : ua_q[31:0];
		op_b = step_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = 64'(op_a) * 64'(op_b);
		unique case (2'(step_q[1]) + 2'(step_q[0]))
			2'd0: pp_sh = {64'd0, pp};
			2'd1: pp_sh = {32'd0, pp, 32'd0};
			default: pp_sh = {pp, 64'd0};
		endcase
		slo = acc_q[FRAC_BITS +: 64];
		shi_nz = |acc_q[127:64+FRAC_BITS];
		mres = (shi_nz || slo[63]) ? {1'b0, {63{1'b1}}} : slo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= mi4_pkg::mag64(a);
			ub_q  <= mi4_pkg::mag64(b);
			neg_q <= a[63] != b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				p_q <= neg_q ? -$signed(mres) : $signed(mres);
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

### rtl/core/mi4_div.sv
module mi4_div #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mi4_pkg::wide_t     num,
	input  mi4_pkg::wide_t     den,
	output logic               done,
	output logic signed [31:0] q
);

	// Restoring division, one quotient bit per cycle, stopping early once
	// the quotient no longer fits in 32 bits.
	logic         busy_q;
	logic [6:0]   cnt_q;
	logic [127:0] dvd_q;
	logic [63:0]  ud_q;
	logic [63:0]  r_q;
	logic [32:0]  quo_q;
	logic         neg_q;
	logic         done_q;
	logic [31:0]  q_q;

	logic [64:0] r2;
	logic        ge;
	logic [64:0] rn;
	logic [32:0] qn;
	logic [31:0] qsat;

	always_comb begin
		r2 = {r_q, dvd_q[127]};
		ge = r2 >= {1'b0, ud_q};
		rn = ge ? (r2 - {1'b0, ud_q}) : r2;
		qn = {quo_q[31:0], ge};
		if (neg_q) begin
			qsat = (qn > 33'h080000000) ? 32'h80000000 : qn[31:0];
			qsat = 32'd0 - qsat;
		end else begin
			qsat = (qn > 33'h07FFFFFFF) ? 32'h7FFFFFFF : qn[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd127;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (qn[32] || cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {64'd0, mi4_pkg::mag64(num)} << FRAC_BITS;
			ud_q  <= mi4_pkg::mag64(den);
			r_q   <= '0;
			quo_q <= '0;
			neg_q <= num[63] != den[63];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[126:0], 1'b0};
			r_q   <= rn[63:0];
			quo_q <= qn;
			q_q   <= qsat;
		end
	end

	assign done = done_q;
	assign q    = $signed(q_q);

endmodule
